### rtl/core/sct_pkg.sv
`default_nettype none

package sct_pkg;

  localparam logic FUNC_SIN = 1'b0;
  localparam logic FUNC_COS = 1'b1;

  localparam int DIV_W = 10;

  localparam logic [41:0] PI_Q40      = 42'd3454217652358;
  localparam logic [41:0] PI_HALF_Q40 = 42'd1727108826179;

  localparam logic signed [42:0] ONE_Q40 = 43'sh100_0000_0000;
  localparam logic signed [42:0] TWO_Q40 = 43'sh200_0000_0000;

  localparam logic [49:0] RED_OFS     = {2'b00, PI_Q40, 6'd0};
  localparam logic [49:0] RED_OFS_COS = RED_OFS + 50'(PI_HALF_Q40);

  localparam logic [16:0] RECIP_PI = 17'((59'd1 << 58) / 59'(PI_Q40));

  typedef struct packed {
    logic [41:0]        x;
    logic [43:0]        x2;
    logic               odd;
    logic signed [42:0] t;
  } sct_item_t;

endpackage

`default_nettype wire

### rtl/core/sct_horner_step.sv
`default_nettype none

module sct_horner_step
  import sct_pkg::*;
#(
  parameter int unsigned TERM = 1
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      en,
  input  wire logic      in_vld,
  input  var  sct_item_t in_item,
  output logic           out_vld,
  output sct_item_t      out_item
);

  localparam int unsigned        D       = (2 * TERM) * (2 * TERM + 1);
  localparam logic [DIV_W-1:0]   D_W     = DIV_W'(D);
  localparam logic [45:0]        HALF_D  = 46'(D / 2);
  localparam logic [45:0]        TWICE_D = 46'(2 * D);
  localparam logic [43:0]        RECIP_D = 44'((47'd1 << 46) / 47'(D));

  logic [5:0]  v_r;
  sct_item_t   itm_r [6];

  logic [43:0] pp00_r, pp10_r;
  logic [41:0] pp01_r, pp11_r;
  logic [45:0] n2_r, n3_r, n4_r, n5_r;
  logic [47:0] pn00_r;
  logic [43:0] pn01_r;
  logic [45:0] pn10_r;
  logic [41:0] pn11_r;
  logic [43:0] qe4_r, qe5_r;
  logic [45:0] prod5_r;

  logic [42:0] t_abs;
  logic [41:0] tm;
  logic [85:0] psum;
  logic [85:0] pround;
  logic [45:0] n_nxt;
  logic [89:0] qsum;
  logic [53:0] prod_full;
  logic [45:0] rem;
  logic [43:0] q_fix;
  logic [44:0] t_sum;
  sct_item_t   itm_nxt;

  assign t_abs = in_item.t[42] ? (~in_item.t + 43'd1) : in_item.t;
  assign tm    = t_abs[41:0];

  assign psum   = 86'(pp00_r) + (86'(pp01_r) << 22) + (86'(pp10_r) << 22) + (86'(pp11_r) << 44);
  assign pround = psum + (86'd1 << 39);
  assign n_nxt  = pround[85:40] + HALF_D;

  assign qsum = 90'(pn00_r) + (90'(pn01_r) << 24) + (90'(pn10_r) << 24) + (90'(pn11_r) << 48);

  assign prod_full = 54'(qe4_r) * 54'(D_W);

  assign rem   = n5_r - prod5_r;
  assign q_fix = qe5_r + 44'(rem >= 46'(D_W));
  assign t_sum = itm_r[4].t[42] ? (45'(ONE_Q40) + 45'(q_fix)) : (45'(ONE_Q40) - 45'(q_fix));

  always_comb begin
    itm_nxt   = itm_r[4];
    itm_nxt.t = t_sum[42:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[4:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pp00_r   <= in_item.x2[21:0] * tm[21:0];
      pp01_r   <= in_item.x2[21:0] * tm[41:22];
      pp10_r   <= in_item.x2[43:22] * tm[21:0];
      pp11_r   <= in_item.x2[43:22] * tm[41:22];
      itm_r[0] <= in_item;

      n2_r     <= n_nxt;
      itm_r[1] <= itm_r[0];

      pn00_r   <= n2_r[23:0] * RECIP_D[23:0];
      pn01_r   <= n2_r[23:0] * RECIP_D[43:24];
      pn10_r   <= n2_r[45:24] * RECIP_D[23:0];
      pn11_r   <= n2_r[45:24] * RECIP_D[43:24];
      n3_r     <= n2_r;
      itm_r[2] <= itm_r[1];

      qe4_r    <= qsum[89:46];
      n4_r     <= n3_r;
      itm_r[3] <= itm_r[2];

      prod5_r  <= prod_full[45:0];
      qe5_r    <= qe4_r;
      n5_r     <= n4_r;
      itm_r[4] <= itm_r[3];

      itm_r[5] <= itm_nxt;
    end
  end

  assign out_vld  = v_r[5];
  assign out_item = itm_r[5];

  a_quot_under : assert property (@(posedge clk) disable iff (!rst_n)
    v_r[4] |-> prod5_r <= n5_r)
    else $error("quotient estimate too large");

  a_quot_close : assert property (@(posedge clk) disable iff (!rst_n)
    v_r[4] |-> rem < TWICE_D)
    else $error("quotient estimate off by more than one");

  a_t_range : assert property (@(posedge clk) disable iff (!rst_n)
    v_r[5] |-> (itm_r[5].t <= TWO_Q40) && (itm_r[5].t >= -TWO_Q40))
    else $error("series term out of range");

endmodule

`default_nettype wire

### rtl/core/sine_cosine_taylor_unit.sv
// Fixed-point sine / cosine unit.
// Input beat: in_func selects sine (0) or cosine (1), in_angle is radians in
// signed Q8.24. Output beat: out_value, signed Q2.30.
// Both channels use valid/stall; a beat moves when valid is high and stall low.
// The angle is folded into [0, pi) with a reciprocal multiply and a one-step
// correction, then the odd series is evaluated in Horner form, one pipelined
// step for each term after the first, each step holding a split multiply, a
// rounded divide by a constant (reciprocal multiply plus correction) and the
// update. Registered stages cover input folding and squaring, each Horner
// step, and the final multiply, rounding and the output register.
// Throughput: one beat per cycle unless out_stall freezes the pipeline;
// every stage is registered and fed in each enabled cycle.
// When out_valid is held under out_stall the whole pipeline freezes and
// in_stall rises in the same cycle; nothing is dropped or repeated.
// Reset (rst_n low, synchronous) clears all valid bits; data is not reset.
`default_nettype none

module sine_cosine_taylor_unit
  import sct_pkg::*;
#(
  parameter int SERIES_TERMS = 10
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_func,
  input  wire logic [31:0] in_angle,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      out_value
);

  logic        pipe_en;
  logic [6:0]  pv_r;
  logic [2:0]  fv_r;

  logic [49:0] a0_r, a1_r, a2_r;
  logic [6:0]  qe1_r;
  logic [49:0] qpi2_r;
  logic        par2_r, par3_r;
  logic [43:0] rest3_r;
  logic [41:0] x4_r, x5_r;
  logic        odd4_r, odd5_r;
  logic [41:0] xx00_r, xx01_r, xx10_r, xx11_r;
  sct_item_t   item6_r;

  logic [41:0] fp00_r, fp01_r, fp10_r, fp11_r;
  logic        neg_f1_r, neg_f2_r;
  logic [43:0] ymag_r;
  logic [31:0] out_value_r;

  logic [49:0] a_ext;
  logic [49:0] a_ofs;
  logic [42:0] qprod;
  logic [49:0] qpi;
  logic [49:0] rdiff;
  logic        r_ge;
  logic [43:0] r_fold;
  logic [83:0] xsum;
  logic [83:0] xround;
  sct_item_t   item_nxt;

  sct_item_t   chain_item [SERIES_TERMS];
  logic [SERIES_TERMS-1:0] chain_vld;

  sct_item_t   fin;
  logic [42:0] ft_abs;
  logic [41:0] ftm;
  logic [83:0] fsum;
  logic [83:0] fround;
  logic [44:0] om;
  logic [34:0] ym;
  logic [31:0] val_nxt;

  assign pipe_en  = !(fv_r[2] && out_stall);
  assign in_stall = !pipe_en;

  assign a_ext = {{2{in_angle[31]}}, in_angle, 16'd0};
  assign a_ofs = a_ext + ((in_func == FUNC_COS) ? RED_OFS_COS : RED_OFS);

  assign qprod = 43'(a0_r[49:24]) * 43'(RECIP_PI);
  assign qpi   = 50'(qe1_r) * 50'(PI_Q40);
  assign rdiff = a2_r - qpi2_r;

  assign r_ge   = rest3_r >= 44'(PI_Q40);
  assign r_fold = r_ge ? (rest3_r - 44'(PI_Q40)) : rest3_r;

  assign xsum   = 84'(xx00_r) + (84'(xx01_r) << 21) + (84'(xx10_r) << 21) + (84'(xx11_r) << 42);
  assign xround = xsum + (84'd1 << 39);

  always_comb begin
    item_nxt.x   = x5_r;
    item_nxt.x2  = xround[83:40];
    item_nxt.odd = odd5_r;
    item_nxt.t   = ONE_Q40;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r <= '0;
      fv_r <= '0;
    end else if (pipe_en) begin
      pv_r <= {pv_r[5:0], in_valid};
      fv_r <= {fv_r[1:0], chain_vld[SERIES_TERMS-1]};
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      a0_r    <= a_ofs;

      a1_r    <= a0_r;
      qe1_r   <= qprod[40:34];

      a2_r    <= a1_r;
      qpi2_r  <= qpi;
      par2_r  <= qe1_r[0];

      rest3_r <= rdiff[43:0];
      par3_r  <= par2_r;

      x4_r    <= r_fold[41:0];
      odd4_r  <= par3_r ^ r_ge;

      xx00_r  <= x4_r[20:0] * x4_r[20:0];
      xx01_r  <= x4_r[20:0] * x4_r[41:21];
      xx10_r  <= x4_r[41:21] * x4_r[20:0];
      xx11_r  <= x4_r[41:21] * x4_r[41:21];
      x5_r    <= x4_r;
      odd5_r  <= odd4_r;

      item6_r <= item_nxt;
    end
  end

  assign chain_item[0] = item6_r;
  assign chain_vld[0]  = pv_r[6];

  for (genvar i = 0; i < SERIES_TERMS - 1; i++) begin : g_term
    sct_horner_step #(
      .TERM(SERIES_TERMS - 1 - i)
    ) u_step (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (pipe_en),
      .in_vld   (chain_vld[i]),
      .in_item  (chain_item[i]),
      .out_vld  (chain_vld[i+1]),
      .out_item (chain_item[i+1])
    );
  end

  assign fin    = chain_item[SERIES_TERMS-1];
  assign ft_abs = fin.t[42] ? (~fin.t + 43'd1) : fin.t;
  assign ftm    = ft_abs[41:0];

  assign fsum   = 84'(fp00_r) + (84'(fp01_r) << 21) + (84'(fp10_r) << 21) + (84'(fp11_r) << 42);
  assign fround = fsum + (84'd1 << 39);

  assign om = 45'(ymag_r) + 45'd512;
  assign ym = om[44:10];

  always_comb begin
    if (neg_f2_r) begin
      if (ym > 35'h0_8000_0000) begin
        val_nxt = 32'h8000_0000;
      end else begin
        val_nxt = ~ym[31:0] + 32'd1;
      end
    end else begin
      if (ym > 35'h0_7fff_ffff) begin
        val_nxt = 32'h7fff_ffff;
      end else begin
        val_nxt = ym[31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      fp00_r      <= fin.x[20:0] * ftm[20:0];
      fp01_r      <= fin.x[20:0] * ftm[41:21];
      fp10_r      <= fin.x[41:21] * ftm[20:0];
      fp11_r      <= fin.x[41:21] * ftm[41:21];
      neg_f1_r    <= fin.t[42] ^ fin.odd;

      ymag_r      <= fround[83:40];
      neg_f2_r    <= neg_f1_r;

      out_value_r <= val_nxt;
    end
  end

  assign out_valid = fv_r[2];
  assign out_value = out_value_r;

  a_fold_coarse : assert property (@(posedge clk) disable iff (!rst_n)
    pv_r[3] |-> rest3_r < 44'({PI_Q40, 1'b0}))
    else $error("half-period estimate off by more than one");

  a_fold_fine : assert property (@(posedge clk) disable iff (!rst_n)
    pv_r[4] |-> x4_r < PI_Q40)
    else $error("folded angle not below pi");

  a_mag_range : assert property (@(posedge clk) disable iff (!rst_n)
    fv_r[1] |-> ymag_r <= 44'(TWO_Q40))
    else $error("result magnitude out of range");

endmodule

`default_nettype wire

### sim/sine_cosine_taylor_unit_tb.sv
`default_nettype none

module sine_cosine_taylor_unit_tb;
  import sct_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int TERMS       = 10;
  localparam int LATENCY     = 6 * TERMS + 4;
  localparam int STALL_LIMIT = 20000;
  localparam longint Q40_PI      = 64'sd3454217652358;
  localparam longint Q40_PI_HALF = 64'sd1727108826179;
  localparam longint Q40_ONE     = 64'sd1 << 40;

  typedef struct {
    logic        func;
    logic [31:0] angle;
    logic        fixed;
    logic [31:0] value;
  } vector_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic        in_func;
  logic [31:0] in_angle;
  logic        out_valid;
  logic        out_stall;
  logic [31:0] out_value;

  logic [31:0] value_q[$];
  int          err_cnt;
  int          idle_cycles;
  int          send_idle_pct;
  int          recv_stall_pct;
  bit          timed_out;

  sine_cosine_taylor_unit #(.SERIES_TERMS(TERMS)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_func   (in_func),
    .in_angle  (in_angle),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_value (out_value)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic longint sat_mag(longint unsigned m, bit neg);
    if (m > (64'd1 << 62)) m = 64'd1 << 62;
    return neg ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint unsigned abs64(longint v);
    return v < 0 ? 64'd0 - longint'(v) : v;
  endfunction

  function automatic longint q40_mul(longint a, longint b);
    logic [127:0] p;
    logic [127:0] mag;
    p = 128'(abs64(a)) * 128'(abs64(b)) + (128'd1 << 39);
    mag = p >> 40;
    if (mag >= (128'd1 << 62)) mag = 128'd1 << 62;
    return sat_mag(64'(mag), (a < 0) != (b < 0));
  endfunction

  function automatic longint rdiv(longint v, longint unsigned d);
    return sat_mag((abs64(v) + d / 2) / d, v < 0);
  endfunction

  function automatic logic [31:0] trig_value(logic func, logic [31:0] angle);
    longint a, q, r, x2, t, y, v;
    longint unsigned d;
    a = longint'($signed(angle)) * 65536;
    if (func == FUNC_COS) a += Q40_PI_HALF;
    q = a / Q40_PI;
    r = a % Q40_PI;
    if (r < 0) begin
      r += Q40_PI;
      q--;
    end
    x2 = q40_mul(r, r);
    t = Q40_ONE;
    for (int k = TERMS - 1; k >= 1; k--) begin
      d = longint'(2 * k) * longint'(2 * k + 1);
      t = Q40_ONE - rdiv(q40_mul(x2, t), d);
    end
    y = q40_mul(r, t);
    if (q[0]) y = -y;
    v = sat_mag((abs64(y) + 64'd512) >> 10, y < 0);
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    return v[31:0];
  endfunction

  task automatic send_beat(logic func, logic [31:0] angle);
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_func  <= func;
    in_angle <= angle;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic push_checked(logic func, logic [31:0] angle);
    value_q.push_back(trig_value(func, angle));
    send_beat(func, angle);
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      out_stall <= (recv_stall_pct > 0) && ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (value_q.size() == 0) begin
        $display("%0t: unexpected beat, actual %h", $time, out_value);
        err_cnt++;
      end else begin
        if (out_value !== value_q[0]) begin
          $display("%0t: value mismatch, expected %h actual %h", $time, value_q[0],
                   out_value);
          err_cnt++;
        end
        void'(value_q.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT && !timed_out) begin
        timed_out = 1'b1;
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  vector_t vectors[] = '{
    '{FUNC_SIN, 32'h0000_0000, 1'b1, 32'h0000_0000},
    '{FUNC_COS, 32'h0000_0000, 1'b1, 32'h4000_0000},
    '{FUNC_SIN, 32'h7FFF_FFFF, 1'b0, 32'h0},
    '{FUNC_COS, 32'h7FFF_FFFF, 1'b0, 32'h0},
    '{FUNC_SIN, 32'h8000_0000, 1'b0, 32'h0},
    '{FUNC_COS, 32'h8000_0000, 1'b0, 32'h0},
    '{FUNC_SIN, 32'h0192_1FB5, 1'b0, 32'h0},
    '{FUNC_SIN, 32'h0324_3F6A, 1'b0, 32'h0},
    '{FUNC_SIN, 32'h0324_3F6B, 1'b0, 32'h0},
    '{FUNC_SIN, 32'hFCDB_C096, 1'b0, 32'h0},
    '{FUNC_COS, 32'hFE6D_E04B, 1'b0, 32'h0},
    '{FUNC_COS, 32'h0192_1FB5, 1'b0, 32'h0},
    '{FUNC_SIN, 32'hFFFF_FFFF, 1'b0, 32'h0},
    '{FUNC_COS, 32'h0000_0001, 1'b0, 32'h0},
    '{FUNC_SIN, 32'h5555_5555, 1'b0, 32'h0},
    '{FUNC_COS, 32'hAAAA_AAAA, 1'b0, 32'h0}
  };

  initial begin
    logic [31:0] ang;
    int wait_cnt;
    err_cnt = 0;
    timed_out = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_func = 1'b0;
    in_angle = '0;
    out_stall = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (vectors[i]) begin
      value_q.push_back(vectors[i].fixed ? vectors[i].value :
                        trig_value(vectors[i].func, vectors[i].angle));
      send_beat(vectors[i].func, vectors[i].angle);
    end

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 81; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 81; end
        default: begin send_idle_pct = 36; recv_stall_pct = 36; end
      endcase
      for (int n = 0; n < 285; n++) begin
        case ($urandom_range(3))
          0: ang = $urandom();
          1: ang = $urandom_range(32'h0700_0000) - 32'h0380_0000;
          2: ang = {$urandom_range(1) ? 8'hFF : 8'h00, 24'($urandom())};
          default: ang = $urandom_range(1) ? 32'h7FFF_FFFF - $urandom_range(255)
                                           : 32'h8000_0000 + $urandom_range(255);
        endcase
        push_checked(1'($urandom_range(1)), ang);
      end
      in_valid <= 1'b0;
      wait_cnt = 0;
      while (value_q.size() > 0 && wait_cnt < STALL_LIMIT) begin
        @(posedge clk);
        wait_cnt++;
      end
    end

    send_idle_pct = 0;
    recv_stall_pct = 0;
    wait_cnt = 0;
    while (value_q.size() > 0 && wait_cnt < STALL_LIMIT) begin
      @(posedge clk);
      wait_cnt++;
    end
    repeat (LATENCY + 10) @(posedge clk);
    if (value_q.size() > 0) begin
      $display("%0t: %0d expected values never arrived, next expected %h", $time,
               value_q.size(), value_q[0]);
      err_cnt++;
    end
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

`default_nettype wire

### filelist.f
rtl/core/sct_pkg.sv
rtl/core/sct_horner_step.sv
rtl/core/sine_cosine_taylor_unit.sv
sim/sine_cosine_taylor_unit_tb.sv
